// ===== hw/rtl/bfha_pkg.sv =====
package bfha_pkg;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // Reset value of the holes-in-use register
  localparam logic [4:0] HOLES_IN_USE_RESET = 5'd16;

  // Input item
  typedef struct packed {
    logic        req_type;
    logic [3:0]  hole_index;
    logic [15:0] size_value;
  } req_t;

  // Result item
  typedef struct packed {
    logic        granted;
    logic [3:0]  chosen_hole;
    logic [15:0] remaining_size;
  } rsp_t;

endpackage

// ===== hw/rtl/bfha_hole_mem.sv =====
module bfha_hole_mem #(
  parameter int HOLES     = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [$clog2(HOLES)-1:0]   wr_addr,
  input  logic [SIZE_BITS-1:0]       wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(HOLES)-1:0]   rd_addr,
  output logic [SIZE_BITS-1:0]       rd_data
);

  logic [SIZE_BITS-1:0] mem [HOLES];
  logic [HOLES-1:0]     valid;

  // Track written entries; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

// ===== hw/rtl/bfha_best_cmp.sv =====
module bfha_best_cmp #(
  parameter int HOLES     = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       en,
  input  logic [$clog2(HOLES)-1:0]   cand_idx,
  input  logic [SIZE_BITS-1:0]       cand_size,
  input  logic [SIZE_BITS-1:0]       req_size,
  output logic                       found,
  output logic [$clog2(HOLES)-1:0]   best_idx,
  output logic [SIZE_BITS-1:0]       best_size
);

  logic fits;
  logic better;

  // A hole fits if it covers the request; strictly smaller wins so ties keep the lower index
  assign fits   = (cand_size >= req_size);
  assign better = fits && (!found || (cand_size < best_size));

  // Hold the best candidate seen so far
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
    end else if (en && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && better) begin
      best_idx  <= cand_idx;
      best_size <= cand_size;
    end
  end

endmodule

// ===== hw/rtl/best_fit_hole_allocator.sv =====
// Best-fit hole allocator.
// A load item writes one hole at acceptance; it gives no result.
// An allocate item stalls the input while it reads the hole table once per hole in use,
// N = min(holes_in_use, HOLES), compares the last read in a drain step and then writes back
// (with no reads and no drain when N is 0); a held result stalls write-back.
// Synchronous reset clears all holes to zero and holes_in_use to 16.
module best_fit_hole_allocator #(
  parameter int HOLES     = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  bfha_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bfha_pkg::rsp_t out_data
);

  localparam int AW    = $clog2(HOLES);
  localparam int CNT_W = $clog2(HOLES + 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    WRITE
  } state_t;

  state_t               state;
  logic [4:0]           holes_in_use;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [AW-1:0]        scan_addr;
  logic [AW-1:0]        rd_idx;
  logic                 rd_valid;
  logic [SIZE_BITS-1:0] req_size;
  logic [SIZE_BITS-1:0] rd_data;
  logic [SIZE_BITS-1:0] rem_size;
  logic                 found;
  logic [AW-1:0]        best_idx;
  logic [SIZE_BITS-1:0] best_size;
  logic                 in_accept;
  logic                 load_ok;
  logic                 last_addr;
  logic                 out_free;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [8:0]           hiu_ext;

  assign in_stall  = (state != IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign load_ok   = (9'(in_data.hole_index) < 9'(HOLES));
  assign last_addr = (CNT_W'(scan_addr) == (count - CNT_W'(1)));
  assign rem_size  = best_size - req_size;

  // Clamp the holes-in-use count to the table depth
  always_comb begin
    hiu_ext = 9'(holes_in_use);
    if (hiu_ext > 9'(HOLES)) begin
      count_next = CNT_W'(HOLES);
    end else begin
      count_next = CNT_W'(hiu_ext);
    end
  end

  // Table write: a load at acceptance, or the write-back of a granted hole
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx;
    wr_data = rem_size;
    if (in_accept && (in_data.req_type == bfha_pkg::REQ_LOAD)) begin
      wr_en   = load_ok;
      wr_addr = AW'(in_data.hole_index);
      wr_data = SIZE_BITS'(in_data.size_value);
    end else if ((state == WRITE) && out_free) begin
      wr_en = found;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      holes_in_use <= bfha_pkg::HOLES_IN_USE_RESET;
    end else if (cfg_we) begin
      holes_in_use <= cfg_data;
    end
  end

  // Sequencer: scan reads, drain the last compare, write back and post the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= (state == SCAN);
      rd_idx   <= scan_addr;
      if (out_valid && !out_stall && (state != WRITE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_accept && (in_data.req_type == bfha_pkg::REQ_ALLOC)) begin
            req_size  <= SIZE_BITS'(in_data.size_value);
            count     <= count_next;
            scan_addr <= '0;
            state     <= (count_next == '0) ? WRITE : SCAN;
          end
        end
        SCAN: begin
          if (last_addr) begin
            state <= DRAIN;
          end else begin
            scan_addr <= scan_addr + AW'(1);
          end
        end
        DRAIN: begin
          state <= WRITE;
        end
        WRITE: begin
          if (out_free) begin
            out_valid                <= 1'b1;
            out_data.granted         <= found;
            out_data.chosen_hole     <= found ? 4'(best_idx) : 4'd0;
            out_data.remaining_size  <= found ? 16'(rem_size) : 16'd0;
            state                    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  bfha_hole_mem #(
    .HOLES     (HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (state == SCAN),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  bfha_best_cmp #(
    .HOLES     (HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_cmp (
    .clk       (clk),
    .rst       (rst),
    .clear     (in_accept),
    .en        (rd_valid),
    .cand_idx  (rd_idx),
    .cand_size (rd_data),
    .req_size  (req_size),
    .found     (found),
    .best_idx  (best_idx),
    .best_size (best_size)
  );

  // A refused allocate reports zero index and zero size
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.granted) |->
      (out_data.chosen_hole == 4'd0) && (out_data.remaining_size == 16'd0))
    else $error("no-fit result carries nonzero fields");

  // The scan never reads past the holes in use
  assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> (CNT_W'(scan_addr) < count))
    else $error("scan address beyond holes in use");

  // An accepted allocate stalls the input on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && (in_data.req_type == bfha_pkg::REQ_ALLOC)) |=> in_stall)
    else $error("input not stalled during allocate");

  // A new result only comes from the write-back step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == WRITE))
    else $error("result posted outside write-back");

endmodule
